// File: hdl/rti_pkg.sv
package rti_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int EDGE_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int LO_W       = EDGE_W + 1;
  localparam int HI_W       = CROSS_W - LO_W;
  localparam int PLO_W      = EDGE_W + LO_W + 1;
  localparam int PHI_W      = EDGE_W + HI_W;
  localparam int DOT_W      = EDGE_W + CROSS_W + 2;
  localparam int MAG_W      = DOT_W - 1;
  localparam int QUO_W      = COORD_W - 1;
  localparam int NUM_W      = MAG_W + QUO_W + 1;
  localparam int FRONT_STAGES = 8;
  localparam int DIV_STAGES = QUO_W + 1;
  localparam int NUM_REGS   = 6;
  localparam int ADDR_W     = 5;

  localparam logic [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert0_x;
    logic signed [COORD_W-1:0] vert0_y;
    logic signed [COORD_W-1:0] vert0_z;
    logic signed [COORD_W-1:0] vert1_x;
    logic signed [COORD_W-1:0] vert1_y;
    logic signed [COORD_W-1:0] vert1_z;
    logic signed [COORD_W-1:0] vert2_x;
    logic signed [COORD_W-1:0] vert2_y;
    logic signed [COORD_W-1:0] vert2_z;
  } triangle_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] distance;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] direction_x;
    logic signed [COORD_W-1:0] direction_y;
    logic signed [COORD_W-1:0] direction_z;
  } ray_t;

  typedef struct packed {
    logic             ok;
    logic [MAG_W-1:0] det;
    logic [MAG_W-1:0] tnum;
  } mid_item_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  typedef struct packed {
    logic             ok;
    logic             sat;
    logic [QUO_W-1:0] quo;
    logic [NUM_W-1:0] rem;
    logic [MAG_W-1:0] det;
  } div_stage_t;

  function automatic logic signed [EDGE_W-1:0] sx(input logic signed [COORD_W-1:0] x);
    return {x[COORD_W-1], x};
  endfunction

endpackage

// File: hdl/rti_front.sv
module rti_front import rti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ray_t      ray,
  input  logic      push,
  input  triangle_t triangle,
  output logic      full,
  input  q_status_t mid_status,
  output logic      mid_push,
  output mid_item_t mid_item
);

  logic [FRONT_STAGES-1:0] vld;
  logic en;

  logic signed [COORD_W-1:0] v0 [3];
  logic signed [COORD_W-1:0] v1 [3];
  logic signed [COORD_W-1:0] v2 [3];
  logic signed [COORD_W-1:0] ov [3];
  logic signed [COORD_W-1:0] dc [3];

  logic signed [EDGE_W-1:0] e1_0 [3], e2_0 [3], s_0 [3], d_0 [3];
  logic signed [EDGE_W-1:0] e1_1 [3], e2_1 [3], s_1 [3], d_1 [3];
  logic signed [EDGE_W-1:0] e1_2 [3], e2_2 [3], s_2 [3], d_2 [3];
  logic signed [PROD_W-1:0] ph [6];
  logic signed [PROD_W-1:0] pq [6];
  logic signed [CROSS_W-1:0] h [3];
  logic signed [CROSS_W-1:0] q [3];
  logic signed [EDGE_W-1:0] xa [12];
  logic signed [CROSS_W-1:0] ya [12];
  logic signed [PLO_W-1:0] plo [12];
  logic signed [PHI_W-1:0] phi [12];
  logic signed [DOT_W-1:0] term [12];
  logic signed [DOT_W-1:0] dot [4];
  logic signed [DOT_W-1:0] an, un, vn, tn;
  logic nz;
  logic signed [DOT_W-1:0] uv;

  assign en       = !(vld[FRONT_STAGES-1] && mid_status.full);
  assign full     = !en;
  assign mid_push = vld[FRONT_STAGES-1] && en;

  assign v0 = '{triangle.vert0_x, triangle.vert0_y, triangle.vert0_z};
  assign v1 = '{triangle.vert1_x, triangle.vert1_y, triangle.vert1_z};
  assign v2 = '{triangle.vert2_x, triangle.vert2_y, triangle.vert2_z};
  assign ov = '{ray.origin_x, ray.origin_y, ray.origin_z};
  assign dc = '{ray.direction_x, ray.direction_y, ray.direction_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xa[i]     = e1_2[i];
      ya[i]     = h[i];
      xa[3+i]   = s_2[i];
      ya[3+i]   = h[i];
      xa[6+i]   = d_2[i];
      ya[6+i]   = q[i];
      xa[9+i]   = e2_2[i];
      ya[9+i]   = q[i];
    end
  end

  assign uv = un + vn;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[FRONT_STAGES-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_0[i] <= sx(v1[i]) - sx(v0[i]);
        e2_0[i] <= sx(v2[i]) - sx(v0[i]);
        s_0[i]  <= sx(ov[i]) - sx(v0[i]);
        d_0[i]  <= sx(dc[i]);
      end
      ph[0] <= d_0[1] * e2_0[2];
      ph[1] <= d_0[2] * e2_0[1];
      ph[2] <= d_0[2] * e2_0[0];
      ph[3] <= d_0[0] * e2_0[2];
      ph[4] <= d_0[0] * e2_0[1];
      ph[5] <= d_0[1] * e2_0[0];
      pq[0] <= s_0[1] * e1_0[2];
      pq[1] <= s_0[2] * e1_0[1];
      pq[2] <= s_0[2] * e1_0[0];
      pq[3] <= s_0[0] * e1_0[2];
      pq[4] <= s_0[0] * e1_0[1];
      pq[5] <= s_0[1] * e1_0[0];
      e1_1 <= e1_0;
      e2_1 <= e2_0;
      s_1  <= s_0;
      d_1  <= d_0;
      for (int i = 0; i < 3; i++) begin
        h[i] <= CROSS_W'(ph[2*i]) - CROSS_W'(ph[2*i+1]);
        q[i] <= CROSS_W'(pq[2*i]) - CROSS_W'(pq[2*i+1]);
      end
      e1_2 <= e1_1;
      e2_2 <= e2_1;
      s_2  <= s_1;
      d_2  <= d_1;
      for (int k = 0; k < 12; k++) begin
        plo[k] <= xa[k] * $signed({1'b0, ya[k][LO_W-1:0]});
        phi[k] <= xa[k] * $signed(ya[k][CROSS_W-1:LO_W]);
      end
      for (int k = 0; k < 12; k++) begin
        term[k] <= (DOT_W'(phi[k]) <<< LO_W) + DOT_W'(plo[k]);
      end
      for (int j = 0; j < 4; j++) begin
        dot[j] <= term[3*j] + term[3*j+1] + term[3*j+2];
      end
      nz <= (dot[0] != '0);
      if (dot[0][DOT_W-1]) begin
        an <= -dot[0];
        un <= -dot[1];
        vn <= -dot[2];
        tn <= -dot[3];
      end else begin
        an <= dot[0];
        un <= dot[1];
        vn <= dot[2];
        tn <= dot[3];
      end
      mid_item.ok <= nz && !un[DOT_W-1] && !(an < un) && !vn[DOT_W-1] && !(an < uv)
                     && !tn[DOT_W-1] && (tn != '0);
      mid_item.det  <= an[MAG_W-1:0];
      mid_item.tnum <= tn[MAG_W-1:0];
    end
  end

endmodule

// File: hdl/rti_queue.sv
module rti_queue import rti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mid_item_t din,
  input  logic      pop,
  output mid_item_t dout,
  output q_status_t status
);

  mid_item_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic do_pop;

  assign status.full      = (cnt == 2'd2);
  assign status.not_empty = (cnt != 2'd0);
  assign dout   = mem[rp];
  assign do_pop = pop && status.not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

// File: hdl/rti_back.sv
module rti_back import rti_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t mid_status,
  input  mid_item_t mid_item,
  output logic      mid_pop,
  output logic      empty,
  input  logic      pop,
  output result_t   result
);

  div_stage_t st  [DIV_STAGES];
  div_stage_t nxt [DIV_STAGES];
  logic [NUM_W-1:0] shv [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;
  logic en;

  result_t ofifo [2];
  result_t res_in;
  logic wp, rp;
  logic [1:0] cnt;
  logic out_push, out_pop;

  assign en       = !(vld[DIV_STAGES-1] && cnt == 2'd2);
  assign mid_pop  = en && mid_status.not_empty;
  assign out_push = en && vld[DIV_STAGES-1];
  assign out_pop  = pop && (cnt != 2'd0);
  assign empty    = (cnt == 2'd0);
  assign result   = ofifo[rp];

  always_comb begin
    shv[0]      = NUM_W'(mid_item.det) << QUO_W;
    nxt[0].ok   = mid_item.ok;
    nxt[0].det  = mid_item.det;
    nxt[0].quo  = '0;
    nxt[0].rem  = NUM_W'({mid_item.tnum, {FRAC_BITS{1'b0}}});
    nxt[0].sat  = (nxt[0].rem >= shv[0]);
    for (int k = 1; k < DIV_STAGES; k++) begin
      nxt[k] = st[k-1];
      shv[k] = NUM_W'(st[k-1].det) << (QUO_W - k);
      if (!st[k-1].sat && st[k-1].rem >= shv[k]) begin
        nxt[k].rem = st[k-1].rem - shv[k];
        nxt[k].quo[QUO_W-k] = 1'b1;
      end
    end
  end

  always_comb begin
    res_in.hit = st[DIV_STAGES-1].ok;
    if (!st[DIV_STAGES-1].ok) begin
      res_in.distance = '0;
    end else if (st[DIV_STAGES-1].sat) begin
      res_in.distance = DIST_MAX;
    end else begin
      res_in.distance = {1'b0, st[DIV_STAGES-1].quo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (en) begin
        vld <= {vld[DIV_STAGES-2:0], mid_status.not_empty};
      end
      if (out_push) begin
        wp <= !wp;
      end
      if (out_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(out_push) - 2'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= nxt;
    end
    if (out_push) begin
      ofifo[wp] <= res_in;
    end
  end

endmodule

// File: hdl/ray_triangle_intersect_top.sv
// Moller-Trumbore ray/triangle test in exact fixed point. The ray (origin and
// direction, signed Q16.16) sits in six APB registers at byte addresses 0x00 to
// 0x14; the user must write them only while the block is idle, which the block
// itself does not enforce. Each beat pushed is one triangle and gives one result
// beat with a hit flag and the distance t, saturated and 0 on a miss. One
// triangle is taken every cycle while full is low. A triangle passes an 8-stage
// multiply and classify pipeline, a 2-entry queue, a 32-stage restoring divider
// (saturation check, then one quotient bit per stage) and a 2-entry output queue.
module ray_triangle_intersect_top import rti_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  triangle_t         triangle,
  output logic              empty,
  input  logic              pop,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [COORD_W-1:0] cfg [NUM_REGS];
  reg_idx_t  idx;
  ray_t      ray;
  mid_item_t front_item, queue_item;
  logic      mid_push, mid_pop;
  q_status_t mid_status;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign ray    = '{cfg[REG_ORIGIN_X], cfg[REG_ORIGIN_Y], cfg[REG_ORIGIN_Z],
                    cfg[REG_DIRECTION_X], cfg[REG_DIRECTION_Y], cfg[REG_DIRECTION_Z]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg[i] <= (i == int'(REG_DIRECTION_Z)) ? 32'hFFFF0000 : '0;
      end
    end else if (psel && penable && pwrite && paddr[4:2] < 3'(NUM_REGS)) begin
      cfg[paddr[4:2]] <= pwdata;
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:    prdata = cfg[REG_ORIGIN_X];
      REG_ORIGIN_Y:    prdata = cfg[REG_ORIGIN_Y];
      REG_ORIGIN_Z:    prdata = cfg[REG_ORIGIN_Z];
      REG_DIRECTION_X: prdata = cfg[REG_DIRECTION_X];
      REG_DIRECTION_Y: prdata = cfg[REG_DIRECTION_Y];
      REG_DIRECTION_Z: prdata = cfg[REG_DIRECTION_Z];
      default:         prdata = '0;
    endcase
  end

  rti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ray        (ray),
    .push       (push),
    .triangle   (triangle),
    .full       (full),
    .mid_status (mid_status),
    .mid_push   (mid_push),
    .mid_item   (front_item)
  );

  rti_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (mid_push),
    .din    (front_item),
    .pop    (mid_pop),
    .dout   (queue_item),
    .status (mid_status)
  );

  rti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mid_status (mid_status),
    .mid_item   (queue_item),
    .mid_pop    (mid_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_status.full)
    else $error("beat pushed into full middle queue");

  a_miss_zero_distance: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.hit) |-> (result.distance == '0))
    else $error("miss with nonzero distance");

  a_hit_nonneg: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.hit) |-> !result.distance[COORD_W-1])
    else $error("hit with negative distance");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench import rti_pkg::*;;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 60;
  localparam logic [31:0] ONE   = 32'h0001_0000;

  typedef logic signed [127:0] wide_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  triangle_t         triangle = '0;
  logic              empty;
  logic              pop = 1'b0;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  ray_triangle_intersect_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .triangle(triangle),
    .empty(empty), .pop(pop), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ray_t      ray_regs;
  triangle_t pending_tris[$];
  result_t   expected_hits[$];
  logic      quiet = 1'b0;
  int        mismatches = 0;
  int        tris_sent = 0;
  int        results_seen = 0;
  int        hits_seen = 0;
  int        idle_cycles = 0;
  int        push_gap = 0;
  int        pop_gap = 0;

  function automatic result_t predict_hit(triangle_t t, ray_t r);
    wide_t o[3], d[3], v0[3], e1[3], e2[3], s[3], h[3], q[3];
    wide_t det, unum, vnum, tnum;
    logic [127:0] num, quo;
    result_t res;
    res = '0;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.direction_x; d[1] = r.direction_y; d[2] = r.direction_z;
    v0[0] = t.vert0_x; v0[1] = t.vert0_y; v0[2] = t.vert0_z;
    e1[0] = wide_t'(t.vert1_x) - v0[0];
    e1[1] = wide_t'(t.vert1_y) - v0[1];
    e1[2] = wide_t'(t.vert1_z) - v0[2];
    e2[0] = wide_t'(t.vert2_x) - v0[0];
    e2[1] = wide_t'(t.vert2_y) - v0[1];
    e2[2] = wide_t'(t.vert2_z) - v0[2];
    for (int i = 0; i < 3; i++) s[i] = o[i] - v0[i];
    h[0] = d[1] * e2[2] - d[2] * e2[1];
    h[1] = d[2] * e2[0] - d[0] * e2[2];
    h[2] = d[0] * e2[1] - d[1] * e2[0];
    q[0] = s[1] * e1[2] - s[2] * e1[1];
    q[1] = s[2] * e1[0] - s[0] * e1[2];
    q[2] = s[0] * e1[1] - s[1] * e1[0];
    det  = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
    unum = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
    vnum = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
    tnum = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
    if (det == 0) return res;
    if (det < 0) begin
      det = -det; unum = -unum; vnum = -vnum; tnum = -tnum;
    end
    if (unum < 0 || unum > det) return res;
    if (vnum < 0 || unum + vnum > det) return res;
    if (tnum <= 0) return res;
    num = tnum <<< FRAC_BITS;
    quo = num / det;
    res.hit = 1'b1;
    res.distance = (quo > 128'(DIST_MAX)) ? DIST_MAX : quo[31:0];
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (push && full) begin
      push <= 1'b1;
    end else begin
      if (push) begin
        expected_hits.insert(expected_hits.size(), predict_hit(triangle, ray_regs));
        tris_sent++;
      end
      if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        push_gap = $urandom_range(1, 13) - 1;
        push <= 1'b0;
      end else if (pending_tris.size() > 0) begin
        triangle <= pending_tris.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %p", result);
        end else begin
          want = expected_hits.pop_front();
          if (want.hit) hits_seen++;
          if (result.hit !== want.hit || result.distance !== want.distance) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit=%0b dist=%h, got hit=%0b dist=%h",
                       want.hit, want.distance, result.hit, result.distance);
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        pop_gap = $urandom_range(1, 13) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr >> 2)
      REG_ORIGIN_X:    ray_regs.origin_x = value;
      REG_ORIGIN_Y:    ray_regs.origin_y = value;
      REG_ORIGIN_Z:    ray_regs.origin_z = value;
      REG_DIRECTION_X: ray_regs.direction_x = value;
      REG_DIRECTION_Y: ray_regs.direction_y = value;
      REG_DIRECTION_Z: ray_regs.direction_z = value;
      default: ;
    endcase
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
    write_reg(ADDR_W'(REG_ORIGIN_X) << 2, ox);
    write_reg(ADDR_W'(REG_ORIGIN_Y) << 2, oy);
    write_reg(ADDR_W'(REG_ORIGIN_Z) << 2, oz);
    write_reg(ADDR_W'(REG_DIRECTION_X) << 2, dx);
    write_reg(ADDR_W'(REG_DIRECTION_Y) << 2, dy);
    write_reg(ADDR_W'(REG_DIRECTION_Z) << 2, dz);
  endtask

  task automatic wait_idle();
    while (pending_tris.size() > 0 || push || expected_hits.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // vertices in whole units
  task automatic add_tri(int ax, ay, az, bx, by, bz, cx, cy, cz);
    pending_tris.insert(pending_tris.size(),
                        '{ax * ONE, ay * ONE, az * ONE, bx * ONE, by * ONE, bz * ONE,
                          cx * ONE, cy * ONE, cz * ONE});
  endtask

  // triangles placed around a point on the current ray, plus raw noise
  task automatic add_random(int count);
    triangle_t t;
    logic [31:0] c[3], dvec[3], ovec[3], k, span;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 3) begin
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      end else begin
        ovec = '{ray_regs.origin_x, ray_regs.origin_y, ray_regs.origin_z};
        dvec = '{ray_regs.direction_x, ray_regs.direction_y, ray_regs.direction_z};
        k = $urandom_range(0, 3) == 0 ? -$urandom_range(1, 8) : $urandom_range(0, 8);
        span = ONE << $urandom_range(0, 4);
        for (int i = 0; i < 3; i++) c[i] = ovec[i] + k * dvec[i];
        t.vert0_x = c[0] - span + $urandom_range(0, 255);
        t.vert0_y = c[1] - span + $urandom_range(0, 255);
        t.vert0_z = c[2] - span + $urandom_range(0, 255);
        t.vert1_x = c[0] + 2 * span - $urandom_range(0, 255);
        t.vert1_y = c[1] - span + $urandom_range(0, 255);
        t.vert1_z = c[2] + $urandom_range(0, 65535);
        t.vert2_x = c[0] - span + $urandom_range(0, 255);
        t.vert2_y = c[1] + 2 * span - $urandom_range(0, 255);
        t.vert2_z = c[2] + 2 * span - $urandom_range(0, 65535);
        if ($urandom_range(0, 1)) begin
          t = {t.vert0_x, t.vert0_y, t.vert0_z, t.vert2_x, t.vert2_y, t.vert2_z,
               t.vert1_x, t.vert1_y, t.vert1_z};
        end
      end
      pending_tris.insert(pending_tris.size(), t);
    end
  endtask

  initial begin
    ray_regs = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset ray: origin 0, direction -z
    add_tri(-1, -1, -5, 2, -1, -5, -1, 2, -5);
    add_tri(-1, -1, -5, -1, 2, -5, 2, -1, -5);
    add_tri(0, 0, -3, 2, 0, -3, 0, 2, -3);
    add_tri(-1, 0, -3, 1, 0, -3, 0, 2, -3);
    add_tri(0, 0, -1, 1, 1, -2, 2, 2, -3);
    add_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_tri(-1, -1, 5, 2, -1, 5, -1, 2, 5);
    add_tri(-1, -1, 0, 2, -1, 0, -1, 2, 0);
    add_tri(2, -1, -4, 4, -1, -4, 2, 1, -4);
    add_tri(-1, 1, -4, 1, 1, -4, -1, 3, -4);
    add_tri(1, 1, -4, 3, 1, -4, 1, 3, -4);
    add_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
    pending_tris.insert(pending_tris.size(), '{-1, -1, -1, 2, -1, -1, -1, 2, -1});
    pending_tris.insert(pending_tris.size(), {9{32'h8000_0000}});
    pending_tris.insert(pending_tris.size(), {9{32'h7FFF_FFFF}});
    pending_tris.insert(pending_tris.size(),
                        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    add_random(70);
    wait_idle();

    // tiny direction: far hits saturate
    set_ray(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    add_tri(-1, -1, -5, 2, -1, -5, -1, 2, -5);
    add_tri(-1, -1, -40000, 2, -1, -40000, -1, 2, -40000);
    add_random(60);
    wait_idle();

    // huge direction: tiny t reported as zero, extreme origin
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
            32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
    pending_tris.insert(pending_tris.size(),
                        '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFF0,
                          32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFF0,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFF0});
    add_random(60);
    wait_idle();

    // zero direction never hits; writes past the last register are ignored
    set_ray($urandom, $urandom, $urandom, 32'd0, 32'd0, 32'd0);
    write_reg(ADDR_W'(NUM_REGS) << 2, 32'hFFFF_FFFF);
    write_reg(ADDR_W'(NUM_REGS + 1) << 2, 32'h1234_5678);
    add_random(30);
    wait_idle();

    // moderate random rays
    for (int p = 0; p < 2; p++) begin
      set_ray($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000,
              $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000,
              $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000,
              $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000,
              $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000,
              $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
      add_random(60);
      wait_idle();
    end

    // last part runs without stalls
    set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    quiet = 1'b1;
    add_random(50);
    wait_idle();

    $display("sent %0d triangles over seven ray settings, %0d results checked, %0d hits",
             tris_sent, results_seen, hits_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
